/* sv/arpf_pkg.sv */
// Package with the types, constants and helper functions of the anti-replay packet filter.
`default_nettype none

package arpf_pkg;

   localparam int PEERS      = 64;
   localparam int PEER_W     = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int SENDER_W   = 6;
   localparam int SEQ_W      = 32;
   localparam int TIME_W     = 64;
   localparam int WINDOW_W   = 32;
   localparam int COUNT_W    = 32;
   localparam int VERDICT_W  = 3;
   localparam int NUM_VERDICTS = 5;

   localparam logic [WINDOW_W-1:0] TS_WINDOW_RESET = WINDOW_W'(1000);
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

   typedef enum logic [VERDICT_W-1:0] {
      V_ACCEPT = 3'd0,
      V_REPLAY = 3'd1,
      V_STALE  = 3'd2,
      V_NOKEY  = 3'd3,
      V_BADSIG = 3'd4
   } verdict_type;

   typedef struct packed {
      logic [SENDER_W-1:0] sender;
      logic [SEQ_W-1:0]    seq_num;
      logic [TIME_W-1:0]   packet_time;
      logic [TIME_W-1:0]   now_time;
      logic                has_cert;
      logic                sig_ok;
   } req_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic                 key_from_cert;
      logic [COUNT_W-1:0]   verdict_count;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [PEER_W-1:0] addr;
      logic [SEQ_W-1:0]  data;
   } seq_wr_type;

   // Reduces a sender index modulo PEERS, which is a power of two.
   function automatic logic [PEER_W-1:0] peer_of(logic [SENDER_W-1:0] s);
      return PEER_W'(32'(s) % PEERS);
   endfunction

endpackage

`default_nettype wire

/* sv/arpf_seq_store.sv */
// Per-peer store of the last accepted sequence number with valid bits and write forwarding.
`default_nettype none

module arpf_seq_store
   import arpf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [PEER_W-1:0] rd_addr,
   input  wire seq_wr_type        wr,
   output logic [SEQ_W-1:0]       rd_data
);

   logic [SEQ_W-1:0] seq_mem_ff [PEERS];
   logic [SEQ_W-1:0] mem_rd_ff;
   logic [PEERS-1:0] valid_ff;
   logic [PEERS-1:0] valid_in;
   logic             valid_rd_ff;
   logic             fwd_ff;
   logic [SEQ_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         seq_mem_ff[wr.addr] <= wr.data;
      end
      mem_rd_ff <= seq_mem_ff[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         valid_rd_ff <= valid_ff[rd_addr];
         fwd_ff      <= wr.en && (wr.addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr.data;
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (valid_rd_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

`default_nettype wire

/* sv/anti_replay_packet_filter_unit.sv */
// Top level of the anti-replay packet filter: input register, verdict logic and result register.
// A request passes the input register and then the result register; the result strobe rises with the result register.
// Throughput: one transaction per cycle; busy is never asserted and the receiver cannot stall.
// The stored sequence numbers are read from a memory with one write and one registered read
// port, with forwarding from the write of the transaction one stage ahead.
// Reset clears the sequence valid bits, key flags and counters and sets the window to 1000 ms.
`default_nettype none

module anti_replay_packet_filter_unit
   import arpf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_type             req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  wire logic                csr_we,
   input  wire logic [WINDOW_W-1:0] csr_wdata
);

   logic [WINDOW_W-1:0] ts_window_ff;
   logic                accept;
   logic [PEER_W-1:0]   peer;
   logic [TIME_W:0]     age;
   logic                stale;

   logic                s1_valid_ff;
   logic [PEER_W-1:0]   s1_peer_ff;
   logic [SEQ_W-1:0]    s1_seq_ff;
   logic                s1_cert_ff;
   logic                s1_ok_ff;
   logic                s1_stale_ff;

   logic [SEQ_W-1:0]    stored_seq;
   logic [PEERS-1:0]    key_known_ff;
   logic [PEERS-1:0]    key_known_in;
   verdict_type         verdict;
   logic                from_cert;
   seq_wr_type          seq_wr;

   logic [COUNT_W-1:0]  count_ff [NUM_VERDICTS];
   logic [COUNT_W-1:0]  count_cur;
   logic [COUNT_W-1:0]  count_in;

   logic                rsp_strobe_ff;
   rsp_type             rsp_data_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign peer   = peer_of(req_data.sender);

   assign age   = {1'b0, req_data.now_time} - {1'b0, req_data.packet_time};
   assign stale = !age[TIME_W] && (age[TIME_W-1:0] > TIME_W'(ts_window_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_window_ff <= TS_WINDOW_RESET;
      end else if (csr_we) begin
         ts_window_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_peer_ff  <= peer;
      s1_seq_ff   <= req_data.seq_num;
      s1_cert_ff  <= req_data.has_cert;
      s1_ok_ff    <= req_data.sig_ok;
      s1_stale_ff <= stale;
   end

   arpf_seq_store u_seq_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (peer),
      .wr      (seq_wr),
      .rd_data (stored_seq)
   );

   always_comb begin
      from_cert = 1'b0;
      priority if (s1_seq_ff <= stored_seq) begin
         verdict = V_REPLAY;
      end else if (s1_stale_ff) begin
         verdict = V_STALE;
      end else if (!s1_cert_ff && !key_known_ff[s1_peer_ff]) begin
         verdict = V_NOKEY;
      end else begin
         from_cert = s1_cert_ff;
         verdict   = s1_ok_ff ? V_ACCEPT : V_BADSIG;
      end
   end

   always_comb begin
      seq_wr.en    = s1_valid_ff && (verdict == V_ACCEPT);
      seq_wr.addr  = s1_peer_ff;
      seq_wr.data  = s1_seq_ff;
      key_known_in = key_known_ff;
      if (seq_wr.en && s1_cert_ff) begin
         key_known_in[s1_peer_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_known_ff <= '0;
      end else begin
         key_known_ff <= key_known_in;
      end
   end

   assign count_cur = count_ff[verdict];
   assign count_in  = (count_cur == COUNT_MAX) ? count_cur : count_cur + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERDICTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         count_ff[verdict] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.verdict       <= verdict;
      rsp_data_ff.key_from_cert <= from_cert;
      rsp_data_ff.verdict_count <= count_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Every accepted transaction produces a result once it has passed the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result");

   // A result never appears without a transaction accepted ahead of it through the input and result registers.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without an accepted transaction");

   // The certificate key is only reported when the verifier was reached.
   a_cert_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.key_from_cert) |->
         (rsp_data.verdict == V_ACCEPT || rsp_data.verdict == V_BADSIG))
      else $error("key_from_cert set on a verdict that skips the verifier");

   // A counter has been incremented at least once when its verdict is reported.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.verdict_count != '0))
      else $error("verdict reported with a zero count");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the anti-replay packet filter: directed and random packets with a predictor.
`timescale 1ns / 100ps

module tb_top;
   import arpf_pkg::*;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [WINDOW_W-1:0] csr_wdata;

   logic [SEQ_W-1:0]    stored_seq [PEERS];
   bit                  key_seen [PEERS];
   logic [COUNT_W-1:0]  verdict_totals [NUM_VERDICTS];
   logic [WINDOW_W-1:0] window_ms;
   rsp_type             pending_verdicts [$];
   int unsigned         mismatches = 0;
   int unsigned         idle_pct = 0;

   anti_replay_packet_filter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type filter_packet(req_type r);
      int unsigned       p;
      verdict_type       v;
      logic              from_cert;
      logic [TIME_W-1:0] age;
      rsp_type           res;
      p = int'(r.sender) % PEERS;
      from_cert = 1'b0;
      age = r.now_time - r.packet_time;
      if (r.seq_num <= stored_seq[p]) begin
         v = V_REPLAY;
      end else if (r.now_time > r.packet_time && age > TIME_W'(window_ms)) begin
         v = V_STALE;
      end else if (!r.has_cert && !key_seen[p]) begin
         v = V_NOKEY;
      end else begin
         from_cert = r.has_cert;
         if (!r.sig_ok) begin
            v = V_BADSIG;
         end else begin
            v = V_ACCEPT;
            stored_seq[p] = r.seq_num;
            if (r.has_cert) begin
               key_seen[p] = 1'b1;
            end
         end
      end
      if (verdict_totals[v] != COUNT_MAX) begin
         verdict_totals[v] = verdict_totals[v] + 1'b1;
      end
      res.verdict = v;
      res.key_from_cert = from_cert;
      res.verdict_count = verdict_totals[v];
      return res;
   endfunction

   function automatic req_type make_packet(int unsigned sender, logic [SEQ_W-1:0] seq,
                                           logic [TIME_W-1:0] ptime, logic [TIME_W-1:0] now,
                                           logic cert, logic ok);
      req_type r;
      r.sender = SENDER_W'(sender);
      r.seq_num = seq;
      r.packet_time = ptime;
      r.now_time = now;
      r.has_cert = cert;
      r.sig_ok = ok;
      return r;
   endfunction

   function automatic req_type random_packet();
      req_type           r;
      logic [TIME_W-1:0] age;
      logic [SEQ_W-1:0]  last;
      int unsigned       pick;
      r.sender = SENDER_W'($urandom_range(PEERS - 1));
      r.now_time = {$urandom, $urandom};
      r.has_cert = ($urandom_range(99) < 30);
      r.sig_ok = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 12) begin
         r.sender = SENDER_W'($urandom);
         r.seq_num = $urandom;
         r.packet_time = {$urandom, $urandom};
         return r;
      end
      last = stored_seq[int'(r.sender) % PEERS];
      pick = $urandom_range(9);
      if (pick < 7) begin
         r.seq_num = last + SEQ_W'($urandom_range(1, 4));
      end else if (pick == 7) begin
         r.seq_num = last - SEQ_W'($urandom_range(0, 2));
      end else if (pick == 8) begin
         r.seq_num = last + SEQ_W'($urandom_range(1, 1 << 20));
      end else begin
         r.seq_num = $urandom;
      end
      pick = $urandom_range(9);
      case (pick)
         5: age = TIME_W'(window_ms);
         6: age = TIME_W'(window_ms) + 1;
         7: age = TIME_W'(window_ms) + 1 + TIME_W'($urandom_range(0, 1000));
         9: age = '0;
         default: age = TIME_W'($urandom) % (TIME_W'(window_ms) + 1);
      endcase
      if (pick == 8) begin
         r.packet_time = r.now_time + TIME_W'($urandom_range(1, 1000));
      end else begin
         r.packet_time = r.now_time - age;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic send_packet(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_verdicts.push_back(filter_packet(r));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_window(logic [WINDOW_W-1:0] value);
      wait_drained();
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      window_ms = value;
   endtask

   task automatic test_replay_and_key();
      send_packet(make_packet(0, 0, 0, 0, 1'b1, 1'b1));
      send_packet(make_packet(0, 1, 0, 0, 1'b0, 1'b1));
      send_packet(make_packet(0, 1, 0, 0, 1'b1, 1'b0));
      send_packet(make_packet(0, 1, 0, 0, 1'b1, 1'b1));
      send_packet(make_packet(0, 1, 0, 0, 1'b1, 1'b1));
      send_packet(make_packet(0, 2, 0, 0, 1'b0, 1'b1));
      send_packet(make_packet(0, 3, 0, 0, 1'b0, 1'b0));
      send_packet(make_packet(63, '1, '1, '1, 1'b1, 1'b1));
      send_packet(make_packet(63, '1, '1, '1, 1'b1, 1'b1));
   endtask

   task automatic test_time_window();
      send_packet(make_packet(1, 10, 4000, 5000, 1'b1, 1'b1));
      send_packet(make_packet(1, 11, 3999, 5000, 1'b1, 1'b1));
      send_packet(make_packet(1, 12, 5001, 5000, 1'b1, 1'b1));
      send_packet(make_packet(1, 13, '1, 0, 1'b0, 1'b1));
      send_packet(make_packet(1, 14, 0, '1, 1'b0, 1'b1));
   endtask

   task automatic test_window_extremes();
      set_window('0);
      send_packet(make_packet(2, 1, 100, 100, 1'b1, 1'b1));
      send_packet(make_packet(2, 2, 99, 100, 1'b1, 1'b1));
      set_window('1);
      send_packet(make_packet(2, 3, 1, 64'h1_0000_0000, 1'b0, 1'b1));
      send_packet(make_packet(2, 4, 0, 64'h1_0000_0000, 1'b0, 1'b1));
   endtask

   task automatic test_random_traffic(int unsigned count, int unsigned pct,
                                      logic [WINDOW_W-1:0] window);
      set_window(window);
      idle_pct = pct;
      repeat (count) send_packet(random_packet());
      idle_pct = 0;
   endtask

   task automatic test_pause_until_drained();
      idle_pct = 19;
      repeat (20) send_packet(random_packet());
      wait_drained();
      repeat (20) send_packet(random_packet());
      idle_pct = 0;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result with no transaction pending");
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.verdict !== want.verdict) begin
               report_mismatch($sformatf("verdict %0d, predicted %0d",
                                         rsp_data.verdict, want.verdict));
            end
            if (rsp_data.key_from_cert !== want.key_from_cert) begin
               report_mismatch($sformatf("key_from_cert %0b, predicted %0b",
                                         rsp_data.key_from_cert, want.key_from_cert));
            end
            if (rsp_data.verdict_count !== want.verdict_count) begin
               report_mismatch($sformatf("verdict_count %0d, predicted %0d",
                                         rsp_data.verdict_count, want.verdict_count));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      window_ms = TS_WINDOW_RESET;
      foreach (stored_seq[i]) begin
         stored_seq[i] = '0;
         key_seen[i] = 1'b0;
      end
      foreach (verdict_totals[i]) begin
         verdict_totals[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_replay_and_key();
      test_time_window();
      test_window_extremes();
      test_random_traffic(500, 0, TS_WINDOW_RESET);
      test_random_traffic(500, 77, $urandom);
      test_pause_until_drained();
      test_random_traffic(500, 0, '1);
      test_random_traffic(500, 19, $urandom_range(0, 5000));

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
